[rtl/core/alpha_weighted_tile_average_unit_macros.svh]
// Assertion helpers for the tile average unit.
// Compiled out when SYNTHESIS is defined.
`ifndef ALPHA_WEIGHTED_TILE_AVERAGE_UNIT_MACROS_SVH
`define ALPHA_WEIGHTED_TILE_AVERAGE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising edge outside reset.
`define AWTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define AWTA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AWTA_ASSERT(lbl, clk, rst_n, prop, msg)

`define AWTA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/core/awta_pkg.sv]
`default_nettype none

package awta_pkg;

    localparam int CH_W      = 8;
    localparam int WSUM_W    = 24;
    localparam int ASUM_W    = 16;
    localparam int PROD_W    = 2 * CH_W;
    localparam int NUM_CH    = 3;
    localparam int DIV_STEPS = WSUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CH_W-1:0] QUARTER_ALPHA = 8'd64;
    localparam logic [CH_W-1:0] CH_MAX        = 8'hFF;

    typedef struct packed {
        logic [CH_W-1:0] pixel_red;
        logic [CH_W-1:0] pixel_green;
        logic [CH_W-1:0] pixel_blue;
        logic [CH_W-1:0] pixel_alpha;
        logic            last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] avg_red;
        logic [CH_W-1:0] avg_green;
        logic [CH_W-1:0] avg_blue;
        logic [CH_W-1:0] avg_alpha;
        logic            tile_empty;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // add the incoming word to the sums
        logic load;     // final word of the tile: load dividers, clear sums
        logic step;     // one restoring-division step on all lanes
    } ctrl_cmd_t;

endpackage

`default_nettype wire

[rtl/core/alpha_weighted_tile_average_unit.sv]
// Channel  | Signals               | Handshake
// ---------+-----------------------+------------------------------------------
// pixel in | start, busy, pixel    | word taken at a rising edge: start && !busy
// result   | done, result          | one cycle, marked by done; never stalled
//
// A pixel that is not the last of its tile is added to the sums when it is
// taken; words may follow back to back while busy stays low.
// The last pixel is summed in its own cycle, then a restoring divider runs
// 24 steps (one quotient bit per cycle, three color lanes side by side) and
// the result is shown in the cycle after the last step. busy is high only
// during those 24 division steps.
// During the result cycle the next tile's first word can already be taken.
// rst_n clears the state machine and the running sums asynchronously.
`default_nettype none

module alpha_weighted_tile_average_unit
    import awta_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output      logic    busy,
    input  wire pixel_t  pixel,
    output      logic    done,
    output      result_t result
);

    ctrl_cmd_t cmd;

    // sequencer: accept/load/step commands, division step count, done strobe
    awta_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_pixel (pixel.last_pixel),
        .busy       (busy),
        .done       (done),
        .cmd        (cmd)
    );

    // sums, multiply-accumulate and the three divider lanes
    awta_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cmd        (cmd),
        .result     (result)
    );

endmodule

`default_nettype wire

[rtl/core/awta_ctrl.sv]
`default_nettype none

`include "alpha_weighted_tile_average_unit_macros.svh"

module awta_ctrl
    import awta_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      last_pixel,
    output      logic      busy,
    output      logic      done,
    output      ctrl_cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign accept   = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE, ST_EMIT:
            begin
                if (start && last_pixel)
                begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                cmd.load   = start && last_pixel;
            end
            ST_DIVIDE:
            begin
                busy     = 1'b1;
                cmd.step = 1'b1;
            end
            ST_EMIT:
            begin
                done       = 1'b1;
                cmd.accept = start;
                cmd.load   = start && last_pixel;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `AWTA_ASSERT(a_div_entry, clk, rst_n, (state_reg == ST_DIVIDE && $past(state_reg) != ST_DIVIDE) |-> $past(accept && last_pixel), "division entered without a final word")
    `AWTA_ASSERT(a_emit_after_div, clk, rst_n, done |-> ($past(state_reg) == ST_DIVIDE && $past(cnt_last)), "result strobed before division finished")
    `AWTA_ASSERT_NEVER(a_cnt_range, clk, rst_n, state_reg == ST_DIVIDE && cnt_reg > CNT_W'(DIV_STEPS - 1), "division step count out of range")
    `AWTA_ASSERT_NEVER(a_load_while_busy, clk, rst_n, busy && (cmd.accept || cmd.load), "word taken while busy")

endmodule

`default_nettype wire

[rtl/core/awta_datapath.sv]
`default_nettype none

module awta_datapath
    import awta_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pixel_t    pixel,
    input  wire ctrl_cmd_t cmd,
    output      result_t   result
);

    // running sums; cleared at reset and after the final word of a tile
    logic [WSUM_W-1:0] wsum_reg [NUM_CH];
    logic [ASUM_W-1:0] asum_reg;

    // per-lane divider: quotient shifts in where the dividend shifts out
    logic [WSUM_W-1:0] quo_reg  [NUM_CH];
    logic [ASUM_W-1:0] rem_reg  [NUM_CH];
    logic [ASUM_W-1:0] div_reg;

    logic [CH_W-1:0]   chan     [NUM_CH];
    logic [PROD_W-1:0] prod     [NUM_CH];
    logic [WSUM_W-1:0] wsum_add [NUM_CH];
    logic [ASUM_W-1:0] asum_add;
    logic [WSUM_W-1:0] quo_next [NUM_CH];
    logic [ASUM_W-1:0] rem_next [NUM_CH];
    logic [CH_W-1:0]   avg      [NUM_CH];
    logic              empty;

    assign chan[0] = pixel.pixel_red;
    assign chan[1] = pixel.pixel_green;
    assign chan[2] = pixel.pixel_blue;

    assign asum_add = asum_reg + ASUM_W'(pixel.pixel_alpha);

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_lane
        logic [ASUM_W:0] trial;
        logic [ASUM_W:0] diff;
        logic            ge;

        assign prod[i]     = chan[i] * pixel.pixel_alpha;
        assign wsum_add[i] = wsum_reg[i] + WSUM_W'(prod[i]);

        assign trial       = {rem_reg[i], quo_reg[i][WSUM_W-1]};
        assign diff        = trial - {1'b0, div_reg};
        assign ge          = (trial >= {1'b0, div_reg});
        assign rem_next[i] = ge ? diff[ASUM_W-1:0] : trial[ASUM_W-1:0];
        assign quo_next[i] = {quo_reg[i][WSUM_W-2:0], ge};

        // saturate wrapped-sum quotients
        assign avg[i] = (|quo_reg[i][WSUM_W-1:CH_W]) ? CH_MAX : quo_reg[i][CH_W-1:0];

        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                quo_reg[i] <= wsum_add[i];
                rem_reg[i] <= '0;
            end
            else if (cmd.step)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    // divisor captured with the final word, final word included
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg <= asum_add;
        end
    end

    assign empty = (div_reg == '0);

    always_comb
    begin
        result.tile_empty = empty;
        result.avg_red    = empty ? '0 : avg[0];
        result.avg_green  = empty ? '0 : avg[1];
        result.avg_blue   = empty ? '0 : avg[2];
        result.avg_alpha  = empty ? '0 : QUARTER_ALPHA;
    end

    // accumulator update
    logic [WSUM_W-1:0] wsum_next [NUM_CH];
    logic [ASUM_W-1:0] asum_next;

    always_comb
    begin
        asum_next = asum_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            wsum_next[i] = wsum_reg[i];
        end
        priority if (cmd.load)
        begin
            asum_next = '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                wsum_next[i] = '0;
            end
        end
        else if (cmd.accept)
        begin
            asum_next = asum_add;
            for (int i = 0; i < NUM_CH; i++)
            begin
                wsum_next[i] = wsum_add[i];
            end
        end
        else
        begin
            // hold
            asum_next = asum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asum_reg <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                wsum_reg[i] <= '0;
            end
        end
        else
        begin
            asum_reg <= asum_next;
            for (int i = 0; i < NUM_CH; i++)
            begin
                wsum_reg[i] <= wsum_next[i];
            end
        end
    end

endmodule

`default_nettype wire
